/* sv/shpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpt_pkg
// Shared types, codes and the crypt-word table for the string hash probe table.
// ----------------------------------------------------------------------------
package shpt_pkg;

  localparam int unsigned CryptWords = 1280;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step;
    logic hash_step;
    logic div_start;
    logic probe_init;
    logic probe_next;
    logic write_slot;
    logic emit;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic slot_valid;
    logic check_match;
    logic lap_done;
  } sts_t;

  localparam logic [31:0] SeedOne  = 32'h7FED7FED;
  localparam logic [31:0] SeedTwo  = 32'hEEEEEEEE;
  localparam logic [31:0] RomSeed0 = 32'h00100001;

  function automatic logic [31:0] seed_next(input logic [31:0] s);
    logic [63:0] p;
    begin
      p = 64'(s) * 64'd125 + 64'd3;
      seed_next = 32'(p % 64'h2AAAAB);
    end
  endfunction

  // Crypt word for a chain type and byte, elaborated into a constant table.
  function automatic logic [31:0] crypt_word(input int unsigned idx);
    logic [31:0] seed;
    logic [31:0] hi;
    logic [31:0] w;
    int unsigned col;
    int unsigned row;
    begin
      seed = RomSeed0;
      w = '0;
      for (col = 0; col < 256; col++) begin
        for (row = 0; row < 5; row++) begin
          seed = seed_next(seed);
          hi = (seed & 32'hFFFF) << 16;
          seed = seed_next(seed);
          if (col + row * 256 == idx) begin
            w = hi | (seed & 32'hFFFF);
          end
        end
      end
      crypt_word = w;
    end
  endfunction

endpackage

/* sv/string_hash_probe_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_probe_table
// Hashes a byte string and inserts or looks it up in a linear-probe table.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a word (cmd_i, char_byte_i, last_char_i) with start; it is taken
//   when busy is low. Non-final bytes give no result. On a final byte,
//   busy rises: a remainder unit finds the start slot, then the probe
//   walk visits slots on the single storage port (read, then compare).
//   A result shows on status_o/slot_o with done_o for one cycle; busy
//   falls in the cycle after done_o. The receiver cannot stall.
//   table_size is written via APB at address 0; the user must write it
//   only while idle, as the block itself does not enforce it.
//   Reset reseeds the chains and starts a clearing pass over the slot
//   store; busy stays high until it ends.
// ----------------------------------------------------------------------------
module string_hash_probe_table #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  char_byte_i,
  input  logic        last_char_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [9:0]  slot_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] table_size_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {21'd0, table_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= 11'd1024;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      table_size_q <= pwdata[10:0];
    end
  end

  shpt_pkg::ctl_t ctl;
  shpt_pkg::sts_t sts;

  shpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_char_i (last_char_i),
    .cmd_i       (cmd_i),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .busy_o      (busy)
  );

  shpt_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .char_byte_i    (char_byte_i),
    .cmd_i          (cmd_i),
    .table_size_i   (table_size_q),
    .result_valid_o (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o)
  );

endmodule

/* sv/shpt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpt_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module shpt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* sv/shpt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpt_datapath
// Hash chains, start-slot divider, probe pointer, slot storage and result.
// ----------------------------------------------------------------------------
module shpt_datapath #(
  parameter int unsigned TableDepth = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shpt_pkg::ctl_t        ctl_i,
  output shpt_pkg::sts_t        sts_o,
  input  logic [7:0]            char_byte_i,
  input  logic                  cmd_i,
  input  logic [10:0]           table_size_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [9:0]            slot_o
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = (SW > 11) ? SW : 11;

  logic [31:0] rom0 [256];
  logic [31:0] rom1 [256];
  logic [31:0] rom2 [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign rom0[g] = shpt_pkg::crypt_word(g);
    assign rom1[g] = shpt_pkg::crypt_word(256 + g);
    assign rom2[g] = shpt_pkg::crypt_word(512 + g);
  end

  logic [31:0] s1_q [3];
  logic [31:0] s2_q [3];
  logic [31:0] s1_n [3];
  logic [31:0] s2_n [3];
  logic [31:0] rw [3];

  assign rw[0] = rom0[char_byte_i];
  assign rw[1] = rom1[char_byte_i];
  assign rw[2] = rom2[char_byte_i];

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      s1_n[t] = rw[t] ^ (s1_q[t] + s2_q[t]);
      s2_n[t] = 32'(char_byte_i) + s2_q[t] + s1_n[t] + (s2_q[t] << 5) + 32'd3;
    end
  end

  logic [31:0] ha_q, hb_q;
  logic        cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < 3; t++) begin
        s1_q[t] <= shpt_pkg::SeedOne;
        s2_q[t] <= shpt_pkg::SeedTwo;
      end
    end else if (ctl_i.hash_step) begin
      for (int t = 0; t < 3; t++) begin
        s1_q[t] <= ctl_i.div_start ? shpt_pkg::SeedOne : s1_n[t];
        s2_q[t] <= ctl_i.div_start ? shpt_pkg::SeedTwo : s2_n[t];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      ha_q  <= s1_n[1];
      hb_q  <= s1_n[2];
      cmd_q <= cmd_i;
    end
  end

  // Active size clamp.
  logic [SW-1:0] size_q;
  logic [CW-1:0] size_w;
  always_comb begin
    size_w = CW'(table_size_i);
    if (size_w == '0) size_w = CW'(1);
    if (size_w > CW'(TableDepth)) size_w = CW'(TableDepth);
  end

  // Restoring divider: one quotient bit per cycle, remainder only.
  logic [SW:0]   rem_q;
  logic [31:0]   dvd_q;
  logic [5:0]    cnt_q;
  logic [SW:0]   rem_sh;
  logic [SW:0]   rem_d;
  logic          div_busy_q;

  assign rem_sh = {rem_q[SW-1:0], dvd_q[31]};
  assign rem_d  = (rem_sh >= {1'b0, size_q}) ? rem_sh - {1'b0, size_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      cnt_q      <= '0;
    end else if (ctl_i.div_start) begin
      div_busy_q <= 1'b1;
      cnt_q      <= 6'd32;
    end else if (div_busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      rem_q  <= '0;
      dvd_q  <= s1_n[0];
      size_q <= SW'(size_w);
    end else if (div_busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign sts_o.div_done = div_busy_q && (cnt_q == 6'd1);

  // Probe pointer and lap counter.
  logic [AW-1:0] pos_q;
  logic [SW-1:0] left_q;
  logic [AW-1:0] pos_inc;

  assign pos_inc = (SW'(pos_q) + SW'(1) == size_q) ? '0 : pos_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.probe_init) begin
      pos_q  <= AW'(rem_d);
      left_q <= size_q;
    end else if (ctl_i.probe_next) begin
      pos_q  <= pos_inc;
      left_q <= left_q - SW'(1);
    end
  end

  assign sts_o.lap_done = (left_q == SW'(1));

  // Clearing pass over the slot store after reset.
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clear_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clear_done = (clr_q == AW'(TableDepth - 1));

  // Slot store: valid bit and both check words.
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [64:0]   ram_wdata;
  logic [64:0]   rd_data;

  assign ram_addr  = ctl_i.clear_step ? clr_q : pos_q;
  assign ram_we    = ctl_i.clear_step || ctl_i.write_slot;
  assign ram_wdata = ctl_i.clear_step ? '0 : {1'b1, ha_q, hb_q};

  shpt_ram #(.Width(65), .Depth(TableDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_data)
  );

  assign sts_o.slot_valid  = rd_data[64];
  assign sts_o.check_match = (rd_data[63:0] == {ha_q, hb_q});

  // Result register.
  logic        res_v_q;
  logic [1:0]  res_st_q;
  logic [9:0]  res_slot_q;
  logic [1:0]  st_w;
  logic [9:0]  sl_w;

  always_comb begin
    sl_w = '0;
    if (cmd_q == shpt_pkg::CMD_INSERT) begin
      if (!rd_data[64]) begin
        st_w = shpt_pkg::ST_INSERTED;
        sl_w = 10'(pos_q);
      end else begin
        st_w = shpt_pkg::ST_FULL;
      end
    end else if (rd_data[64] && sts_o.check_match) begin
      st_w = shpt_pkg::ST_FOUND;
      sl_w = 10'(pos_q);
    end else begin
      st_w = shpt_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_st_q   <= st_w;
      res_slot_q <= sl_w;
    end
  end

  assign result_valid_o = res_v_q;
  assign status_o       = res_st_q;
  assign slot_o         = res_slot_q;

endmodule

/* sv/shpt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpt_ctrl
// Sequencer for the clearing pass, hashing, start-slot division and the probe walk.
// ----------------------------------------------------------------------------
module shpt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           last_char_i,
  input  logic           cmd_i,
  input  shpt_pkg::sts_t sts_i,
  output shpt_pkg::ctl_t ctl_o,
  output logic           busy_o
);

  shpt_pkg::state_e state_q, state_d;
  logic             cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shpt_pkg::S_CLEAR;
      cmd_q   <= shpt_pkg::CMD_INSERT;
    end else begin
      state_q <= state_d;
      if (state_q == shpt_pkg::S_IDLE && start_i) cmd_q <= cmd_i;
    end
  end

  logic stop;
  always_comb begin
    if (cmd_q == shpt_pkg::CMD_INSERT) stop = !sts_i.slot_valid || sts_i.lap_done;
    else stop = !sts_i.slot_valid || sts_i.check_match || sts_i.lap_done;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shpt_pkg::S_CLEAR: if (sts_i.clear_done) state_d = shpt_pkg::S_IDLE;
      shpt_pkg::S_IDLE:  if (start_i && last_char_i) state_d = shpt_pkg::S_DIV;
      shpt_pkg::S_DIV:   if (sts_i.div_done) state_d = shpt_pkg::S_READ;
      shpt_pkg::S_READ:  state_d = shpt_pkg::S_CHECK;
      shpt_pkg::S_CHECK: state_d = stop ? shpt_pkg::S_DONE : shpt_pkg::S_READ;
      shpt_pkg::S_DONE:  state_d = shpt_pkg::S_IDLE;
      default:           state_d = shpt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      shpt_pkg::S_CLEAR: ctl_o.clear_step = 1'b1;
      shpt_pkg::S_IDLE: begin
        busy_o          = 1'b0;
        ctl_o.hash_step = start_i;
        ctl_o.div_start = start_i && last_char_i;
      end
      shpt_pkg::S_DIV:   ctl_o.probe_init = sts_i.div_done;
      shpt_pkg::S_READ:  ;
      shpt_pkg::S_CHECK: begin
        ctl_o.probe_next = !stop;
        ctl_o.emit       = stop;
        ctl_o.write_slot = stop && (cmd_q == shpt_pkg::CMD_INSERT) && !sts_i.slot_valid;
      end
      shpt_pkg::S_DONE:  ;
      default:           ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |=> state_q == shpt_pkg::S_DONE)
    else $error("emit not followed by done");
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == (state_q != shpt_pkg::S_IDLE))
    else $error("busy mismatch");
  a_write_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.write_slot |-> ctl_o.emit && cmd_q == shpt_pkg::CMD_INSERT)
    else $error("write outside insert");
`endif

endmodule

/* test/string_hash_probe_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_probe_table_checker
// Watches the byte, result and register ports of the string hash probe table.
// Keeps its own copy of the three hash chains and the probe table, predicts
// the status and slot for every final byte, and compares each result strobe
// against the oldest prediction. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module string_hash_probe_table_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  char_byte_i,
  input  logic        last_char_i,
  input  logic        done_o,
  input  logic [1:0]  status_o,
  input  logic [9:0]  slot_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  logic [31:0]       crypt_tab [shpt_pkg::CryptWords];
  logic [31:0]       chain_one [3];
  logic [31:0]       chain_two [3];
  logic              entry_used [TABLE_DEPTH];
  logic [31:0]       entry_tag_a [TABLE_DEPTH];
  logic [31:0]       entry_tag_b [TABLE_DEPTH];
  logic [10:0]       size_reg;
  shpt_pkg::status_e status_q [$];
  logic [9:0]        slot_q [$];

  initial begin
    logic [63:0] sd;
    logic [31:0] hi;
    sd = 64'h00100001;
    for (int c = 0; c < 256; c++) begin
      for (int r = 0; r < 5; r++) begin
        sd = (sd * 125 + 3) % 64'h2AAAAB;
        hi = {sd[15:0], 16'h0};
        sd = (sd * 125 + 3) % 64'h2AAAAB;
        crypt_tab[c + r * 256] = hi | {16'h0, sd[15:0]};
      end
    end
  end

  task automatic reseed_chains();
    for (int t = 0; t < 3; t++) begin
      chain_one[t] = 32'h7FED7FED;
      chain_two[t] = 32'hEEEEEEEE;
    end
  endtask

  task automatic predict_byte(input shpt_pkg::cmd_e cmd, input logic [7:0] ch,
                              input logic last);
    logic [31:0] s1;
    logic [31:0] hs;
    logic [31:0] ha;
    logic [31:0] hb;
    int unsigned span;
    int unsigned pos;
    shpt_pkg::status_e st;
    logic [9:0] hit;
    for (int t = 0; t < 3; t++) begin
      s1 = crypt_tab[t * 256 + ch] ^ (chain_one[t] + chain_two[t]);
      chain_two[t] = {24'h0, ch} + chain_two[t] + s1 + (chain_two[t] << 5) + 32'd3;
      chain_one[t] = s1;
    end
    if (!last) return;
    hs = chain_one[0];
    ha = chain_one[1];
    hb = chain_one[2];
    reseed_chains();
    span = size_reg;
    if (span < 1) span = 1;
    if (span > TABLE_DEPTH) span = TABLE_DEPTH;
    pos = hs % span;
    hit = '0;
    st = (cmd == shpt_pkg::CMD_INSERT) ? shpt_pkg::ST_FULL : shpt_pkg::ST_NOT_FOUND;
    for (int n = 0; n < span; n++) begin
      if (cmd == shpt_pkg::CMD_INSERT) begin
        if (!entry_used[pos]) begin
          entry_used[pos] = 1'b1;
          entry_tag_a[pos] = ha;
          entry_tag_b[pos] = hb;
          st = shpt_pkg::ST_INSERTED;
          hit = pos[9:0];
          break;
        end
      end else begin
        if (!entry_used[pos]) break;
        if (entry_tag_a[pos] == ha && entry_tag_b[pos] == hb) begin
          st = shpt_pkg::ST_FOUND;
          hit = pos[9:0];
          break;
        end
      end
      pos = (pos + 1) % span;
    end
    status_q.push_back(st);
    slot_q.push_back(hit);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reseed_chains();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_used[i] = 1'b0;
        entry_tag_a[i] = '0;
        entry_tag_b[i] = '0;
      end
      size_reg = 11'd1024;
      status_q.delete();
      slot_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (done_o) begin
        if (status_q.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d", status_o, slot_o);
          fail_count_o++;
        end else begin
          if (status_o !== status_q[0]) begin
            $error("status: expected %0d, actual %0d", status_q[0], status_o);
            fail_count_o++;
          end
          if (slot_o !== slot_q[0]) begin
            $error("slot: expected %0d, actual %0d", slot_q[0], slot_o);
            fail_count_o++;
          end
          void'(status_q.pop_front());
          void'(slot_q.pop_front());
        end
      end
      if (psel && penable && pwrite && pready && paddr == 2'd0) size_reg = pwdata[10:0];
      if (start && !busy) begin
        predict_byte(shpt_pkg::cmd_e'(cmd_i), char_byte_i, last_char_i);
      end
      pending_o = status_q.size();
    end
  end

endmodule

/* test/string_hash_probe_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_probe_table_test
// Drives byte strings into the string hash probe table across several table
// sizes, including zero, one and oversize values: directed inserts, lookups
// and table-full cases first, then random strings, about half of them lookups
// of stored strings. A checker module predicts and compares; this module gives verdict.
// ----------------------------------------------------------------------------
module string_hash_probe_table_test;

  localparam int WatchLimit = 20000;
  localparam int PoolSize = 48;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [7:0]  char_byte_i;
  logic        last_char_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [9:0]  slot_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          byte_count;
  int          string_count;
  logic [7:0]  pool_bytes [PoolSize][8];
  int          pool_len [PoolSize];
  int          pool_fill;

  string_hash_probe_table dut (.*);

  string_hash_probe_table_checker checker_u (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .char_byte_i, .last_char_i,
    .done_o, .status_o, .slot_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(99);
    n = (r < 65) ? 0 : (r < 94) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (n > 0) start = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_byte(input shpt_pkg::cmd_e cmd, input logic [7:0] ch,
                           input logic last);
    idle_gap();
    start = 1'b1;
    cmd_i = (last || $urandom_range(1)) ? cmd : shpt_pkg::cmd_e'($urandom_range(1));
    char_byte_i = ch;
    last_char_i = last;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    byte_count++;
  endtask

  task automatic send_string(input shpt_pkg::cmd_e cmd, input int idx);
    for (int i = 0; i < pool_len[idx]; i++)
      send_byte(cmd, pool_bytes[idx][i], i == pool_len[idx] - 1);
    string_count++;
  endtask

  task automatic make_string(input int idx, input int len);
    pool_len[idx] = len;
    for (int i = 0; i < len; i++) pool_bytes[idx][i] = 8'($urandom);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [31:0] value);
    settle();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 2'd0;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic random_phase(input int bytes_goal);
    int stop_at;
    int idx;
    int r;
    stop_at = byte_count + bytes_goal;
    while (byte_count < stop_at) begin
      r = $urandom_range(99);
      if (r < 40) begin
        idx = (pool_fill < PoolSize) ? pool_fill : $urandom_range(PoolSize - 1);
        make_string(idx, $urandom_range(8, 1));
        if (pool_fill < PoolSize) pool_fill++;
        send_string(shpt_pkg::CMD_INSERT, idx);
      end else if (r < 85 && pool_fill > 0) begin
        send_string(shpt_pkg::CMD_LOOKUP, $urandom_range(pool_fill - 1));
      end else begin
        make_string(PoolSize - 1, $urandom_range(8, 1));
        send_string(shpt_pkg::cmd_e'($urandom_range(1)), PoolSize - 1);
      end
    end
  endtask

  initial begin
    logic [31:0] sizes [7];
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = 1'b0;
    char_byte_i = '0;
    last_char_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_count = 0;
    string_count = 0;
    pool_fill = 0;
    sizes = '{32'd0, 32'd2, 32'd7, 32'd2047, 32'd16, 32'd3, 32'd1024};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one-byte extremes and an 8-byte mix at reset size, lookups of each and a miss
    pool_len[0] = 1; pool_bytes[0][0] = 8'h00;
    pool_len[1] = 1; pool_bytes[1][0] = 8'hFF;
    pool_len[2] = 8;
    for (int i = 0; i < 8; i++) pool_bytes[2][i] = (i % 2) ? 8'hFF : 8'h00;
    pool_len[3] = 2; pool_bytes[3][0] = 8'hA5; pool_bytes[3][1] = 8'h5A;
    pool_fill = 3;
    for (int i = 0; i < 3; i++) send_string(shpt_pkg::CMD_INSERT, i);
    for (int i = 0; i < 4; i++) send_string(shpt_pkg::CMD_LOOKUP, i);
    send_string(shpt_pkg::CMD_INSERT, 0);
    // single slot: fill it, then full and lookups
    write_size(32'd1);
    send_string(shpt_pkg::CMD_INSERT, 3);
    send_string(shpt_pkg::CMD_INSERT, 1);
    send_string(shpt_pkg::CMD_LOOKUP, 3);
    send_string(shpt_pkg::CMD_LOOKUP, 1);

    foreach (sizes[k]) begin
      write_size(sizes[k]);
      random_phase(70);
    end
    settle();

    $display("covered %0d bytes in %0d strings over %0d table sizes",
             byte_count, string_count, 9);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
